@@ src/pewr_pkg.sv @@
package pewr_pkg;

  localparam int DEVICE_COUNT_DEF = 60;
  localparam int TASK_COUNT_DEF   = 64;

  localparam int DEV_W  = 6;
  localparam int TASK_W = 6;
  localparam int TIME_W = 32;
  localparam int WAKE_W = 64;

  localparam int PERIOD_STEP = 100;
  localparam int LAST_DEV    = 59;
  localparam int LAST_PERIOD = 9000;

  localparam logic CMD_WAIT = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_LOCKED = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } pewr_state_t;

  // wait write broadcast to every cell, the cell with a matching index takes it
  typedef struct packed {
    logic              en;
    logic [DEV_W-1:0]  dev;
    logic [TASK_W-1:0] tsk;
  } pewr_wr_t;

  function automatic logic [TIME_W-1:0] dev_period(input int idx);
    logic [TIME_W-1:0] p;
    if (idx == LAST_DEV) begin
      p = TIME_W'(LAST_PERIOD);
    end else begin
      p = TIME_W'(PERIOD_STEP * (idx + 1));
    end
    return p;
  endfunction

endpackage

@@ src/pewr_cell.sv @@
module pewr_cell
  import pewr_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int TASK_COUNT = TASK_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tok_vld_i,
  input  logic [TASK_COUNT-1:0] wake_i,
  input  logic [TIME_W-1:0]     now_i,
  input  pewr_wr_t              wr_i,
  output logic                  tok_vld_o,
  output logic [TASK_COUNT-1:0] wake_o
);

  localparam logic [TIME_W-1:0] PERIOD = dev_period(IDX);

  logic [TIME_W-1:0]     match_r, match_nxt;
  logic [TASK_COUNT-1:0] set_r, set_nxt;
  logic                  tok_r;
  logic [TASK_COUNT-1:0] wake_r, wake_nxt;
  logic                  hit;
  logic                  sel;
  logic [TASK_COUNT-1:0] onehot;

  always_comb begin
    hit = tok_vld_i && (match_r <= now_i);
    sel = wr_i.en && (wr_i.dev == DEV_W'(IDX));
    for (int j = 0; j < TASK_COUNT; j++) begin
      onehot[j] = (wr_i.tsk == TASK_W'(j));
    end

    match_nxt = match_r;
    set_nxt   = set_r;
    wake_nxt  = wake_i;
    if (hit) begin
      // wraps modulo 2^32
      match_nxt = match_r + PERIOD;
      set_nxt   = '0;
      wake_nxt  = wake_i | set_r;
    end else if (sel) begin
      set_nxt = set_r | onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= PERIOD;
      set_r   <= '0;
      tok_r   <= 1'b0;
    end else begin
      match_r <= match_nxt;
      set_r   <= set_nxt;
      tok_r   <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    wake_r <= wake_nxt;
  end

  assign tok_vld_o = tok_r;
  assign wake_o    = wake_r;

endmodule

@@ src/periodic_event_wait_release.sv @@
// wait item: result registered in the next cycle; a stalled output holds the next item
// tick item: launch register, each cell's token register, then output register
// the tick token walks the cell chain one device per cycle
// one wait item per cycle while idle and output not stalled; none while a tick runs
// reset (rst_n low, synchronous): match times load each device's period, waiting sets clear
module periodic_event_wait_release
  import pewr_pkg::*;
#(
  parameter int DEVICE_COUNT = DEVICE_COUNT_DEF,
  parameter int TASK_COUNT   = TASK_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [DEV_W-1:0]  in_dev,
  input  logic [TASK_W-1:0] in_task_req,
  input  logic              in_task_holds_lock,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [WAKE_W-1:0] out_wake_mask,
  output logic              out_reschedule
);

  pewr_state_t state_r, state_nxt;

  logic              launch_r, launch_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              status_r, status_nxt;
  logic [WAKE_W-1:0] wake_r, wake_nxt;
  logic              resched_r, resched_nxt;

  logic              in_acc;
  logic              out_acc;
  logic              wait_acc;
  logic              tick_acc;
  logic              done;
  pewr_wr_t          wr;

  logic [DEVICE_COUNT:0] tok_vec;
  logic [TASK_COUNT-1:0] wake_c [0:DEVICE_COUNT];

  assign tok_vec[0] = launch_r;
  assign wake_c[0]  = '0;

  for (genvar g = 0; g < DEVICE_COUNT; g++) begin : g_cell
    pewr_cell #(
      .IDX        (g),
      .TASK_COUNT (TASK_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_vld_i (tok_vec[g]),
      .wake_i    (wake_c[g]),
      .now_i     (now_r),
      .wr_i      (wr),
      .tok_vld_o (tok_vec[g+1]),
      .wake_o    (wake_c[g+1])
    );
  end

  assign done     = tok_vec[DEVICE_COUNT];
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign wait_acc = in_acc && (in_cmd == CMD_WAIT);
  assign tick_acc = in_acc && (in_cmd == CMD_TICK);

  always_comb begin
    // out-of-range device matches no cell, so only the priority range is checked here
    wr.en  = wait_acc && !in_task_holds_lock &&
             ({1'b0, in_task_req} < (TASK_W + 1)'(TASK_COUNT));
    wr.dev = in_dev;
    wr.tsk = in_task_req;
  end

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = tick_acc;
    now_nxt       = tick_acc ? in_now_ms : now_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    wake_nxt      = wake_r;
    resched_nxt   = resched_r;

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_TICK;
        end else if (wait_acc) begin
          out_valid_nxt = 1'b1;
          status_nxt    = in_task_holds_lock ? STATUS_LOCKED : STATUS_OK;
          wake_nxt      = '0;
          resched_nxt   = 1'b0;
        end
      end
      ST_TICK: begin
        // output register was empty at launch and nothing else loads it meanwhile
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          wake_nxt      = WAKE_W'(wake_c[DEVICE_COUNT]);
          resched_nxt   = |wake_c[DEVICE_COUNT];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    status_r  <= status_nxt;
    wake_r    <= wake_nxt;
    resched_r <= resched_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_wake_mask  = wake_r;
  assign out_reschedule = resched_r;

  // at most one tick token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one tick token in the cell chain");

  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vec) |-> (state_r == ST_TICK))
    else $error("tick token in flight while idle");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r && (out_status == STATUS_OK))
    else $error("tick completion did not load the result");

  a_resched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_reschedule == (out_wake_mask != '0)))
    else $error("reschedule flag disagrees with wake mask");

  a_lock_nowake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == STATUS_LOCKED)) |-> (out_wake_mask == '0))
    else $error("refused wait carries a wake mask");

  a_tick_launch: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> launch_r && !out_valid_r)
    else $error("tick launched with output register occupied");

endmodule

@@ tb/sv/tb_periodic_event_wait_release.sv @@
`timescale 1ns / 1ps
module tb_periodic_event_wait_release
  import pewr_pkg::*;
();

  localparam int NUM_DEVS       = 60;
  localparam int NUM_TASKS      = 64;
  localparam int PERIOD_UNIT_MS = 100;
  localparam int SLOW_DEV       = 59;
  localparam int SLOW_PERIOD_MS = 9000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              status;
    logic [WAKE_W-1:0] wake_mask;
    logic              reschedule;
  } release_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [DEV_W-1:0]  in_dev;
  logic [TASK_W-1:0] in_task_req;
  logic              in_task_holds_lock;
  logic [TIME_W-1:0] in_now_ms;
  logic              out_valid;
  logic              out_stall;
  logic              out_status;
  logic [WAKE_W-1:0] out_wake_mask;
  logic              out_reschedule;

  // own copy of the timer bank
  logic [TIME_W-1:0] match_ms [NUM_DEVS];
  logic [WAKE_W-1:0] sleepers [NUM_DEVS];
  logic [TIME_W-1:0] sim_ms;

  release_result_t pending_results [$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 38;
  int recv_idle_pct  = 71;
  int hold_request   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  periodic_event_wait_release dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_dev             (in_dev),
    .in_task_req        (in_task_req),
    .in_task_holds_lock (in_task_holds_lock),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_wake_mask      (out_wake_mask),
    .out_reschedule     (out_reschedule)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] period_ms(input int d);
    if (d == SLOW_DEV) begin
      return TIME_W'(SLOW_PERIOD_MS);
    end
    return TIME_W'(PERIOD_UNIT_MS * (d + 1));
  endfunction

  function automatic release_result_t predict_release(input logic cmd, input logic [DEV_W-1:0] dev,
                                                      input logic [TASK_W-1:0] prio,
                                                      input logic lock,
                                                      input logic [TIME_W-1:0] now);
    release_result_t r;
    r = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_WAIT) begin
      if (lock) begin
        r.status = STATUS_LOCKED;
      end else if (int'(dev) < NUM_DEVS && int'(prio) < NUM_TASKS) begin
        sleepers[dev][prio] = 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_DEVS; i++) begin
        if (match_ms[i] <= now) begin
          match_ms[i] = match_ms[i] + period_ms(i);
          r.wake_mask = r.wake_mask | sleepers[i];
          sleepers[i] = '0;
        end
      end
    end
    r.reschedule = |r.wake_mask;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer_item(input logic cmd, input int dev, input int prio, input int lock,
                            input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_dev             <= DEV_W'(dev);
    in_task_req        <= TASK_W'(prio);
    in_task_holds_lock <= lock[0];
    in_now_ms          <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_release(cmd, DEV_W'(dev), TASK_W'(prio), lock[0], now));
    @(negedge clk);
  endtask

  // receiver side: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    release_result_t seen;
    release_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.status     = out_status;
      seen.wake_mask  = out_wake_mask;
      seen.reschedule = out_reschedule;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: status %0b wake %h resched %0b",
                   seen.status, seen.wake_mask, seen.reschedule);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: status %0b/%0b wake %h/%h resched %0b/%0b (expected/actual)",
                     want.status, seen.status, want.wake_mask, seen.wake_mask,
                     want.reschedule, seen.reschedule);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed_cases();
    offer_item(CMD_WAIT, 0, 0, 0, 32'd0);
    offer_item(CMD_WAIT, 59, 63, 0, '1);
    offer_item(CMD_WAIT, 0, 0, 0, 32'd0);     // repeated wait stays one bit
    offer_item(CMD_WAIT, 0, 40, 0, 32'd0);
    offer_item(CMD_WAIT, 60, 7, 0, 32'd0);    // device out of range
    offer_item(CMD_WAIT, 63, 63, 0, '1);
    offer_item(CMD_WAIT, 3, 9, 1, 32'd0);     // lock held, refused
    offer_item(CMD_WAIT, 63, 63, 1, '1);
    offer_item(CMD_TICK, 0, 0, 0, 32'd0);
    offer_item(CMD_TICK, 63, 63, 1, 32'd99);
    offer_item(CMD_TICK, 0, 0, 0, 32'd100);   // match at exactly now
    offer_item(CMD_TICK, 0, 0, 0, 32'd100);
    offer_item(CMD_WAIT, 58, 31, 0, 32'd0);
    offer_item(CMD_WAIT, 1, 1, 0, 32'd0);
    offer_item(CMD_TICK, 0, 0, 0, 32'd5900);
    offer_item(CMD_WAIT, 2, 62, 0, 32'd0);
    offer_item(CMD_TICK, 63, 63, 1, '1);      // everything due
    offer_item(CMD_WAIT, 59, 0, 0, 32'd0);
    offer_item(CMD_TICK, 0, 0, 0, 32'd8999);
    offer_item(CMD_TICK, 0, 0, 0, 32'd18000);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    logic [TIME_W-1:0] now;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        offer_item(CMD_WAIT, $urandom_range(NUM_DEVS - 1), $urandom_range(NUM_TASKS - 1), 0,
                   $urandom);
      end else if (pick < 63) begin
        offer_item(CMD_WAIT, $urandom_range(63), $urandom_range(63), 1, $urandom);
      end else if (pick < 68) begin
        offer_item(CMD_WAIT, $urandom_range(63, NUM_DEVS), $urandom_range(63), 0, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 90) begin
          sim_ms = sim_ms + $urandom_range(250);
          now = sim_ms;
        end else if (pick < 95) begin
          now = $urandom;
        end else begin
          now = sim_ms - $urandom_range(50);
        end
        offer_item(CMD_TICK, $urandom_range(63), $urandom_range(63), $urandom_range(1), now);
      end
    end
  endtask

  // receiver holds off while the sender keeps pushing, so the block backs up
  task automatic test_output_hold_off();
    hold_request = hold_request + 1;
    for (int n = 0; n < 30; n++) begin
      if (n % 10 == 9) begin
        sim_ms = sim_ms + $urandom_range(250);
        offer_item(CMD_TICK, 0, 0, 0, sim_ms);
      end else begin
        offer_item(CMD_WAIT, $urandom_range(NUM_DEVS - 1), $urandom_range(NUM_TASKS - 1), 0,
                   $urandom);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_cmd             = CMD_WAIT;
    in_dev             = '0;
    in_task_req        = '0;
    in_task_holds_lock = 1'b0;
    in_now_ms          = '0;
    out_stall          = 1'b0;
    sim_ms             = '0;
    for (int i = 0; i < NUM_DEVS; i++) begin
      match_ms[i] = period_ms(i);
      sleepers[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 71;
    test_directed_cases();
    test_random_traffic(500);

    send_idle_pct = 71;
    recv_idle_pct = 38;
    test_random_traffic(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_hold_off();
    test_random_traffic(550);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pewr_pkg.sv
src/pewr_cell.sv
src/periodic_event_wait_release.sv
tb/sv/tb_periodic_event_wait_release.sv
